### design/iexq_pkg.sv
// Shared types, widths and codes for the image exposure quality check.
// Used by every module of the block; depends on nothing.
`default_nettype none

package iexq_pkg;

   localparam int MAX_PIXELS = 4194304;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W      = CNT_W + 8;
   localparam int SQ_W       = CNT_W + 16;
   localparam int DEV_W      = SQ_W;
   localparam int CALC_W     = DEV_W + 2;
   localparam int RATIO_W    = 17;
   localparam int PROD_W     = CNT_W + RATIO_W;
   localparam int QUO_W      = 24;
   localparam int ITER_W     = 5;
   localparam int OUT_W      = 23;
   localparam int ADDR_W     = 5;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = 1;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);
   localparam logic [OUT_W-1:0] SAT23   = '1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BRIGHT    = 3'd1;
   localparam logic [2:0] STATUS_DARK      = 3'd2;
   localparam logic [2:0] STATUS_FLAT      = 3'd3;
   localparam logic [2:0] STATUS_MANY_HIGH = 3'd4;
   localparam logic [2:0] STATUS_MANY_LOW  = 3'd5;

   localparam logic [2:0] REG_OVER_LIMIT  = 3'd0;
   localparam logic [2:0] REG_UNDER_LIMIT = 3'd1;
   localparam logic [2:0] REG_MEAN_UPPER  = 3'd2;
   localparam logic [2:0] REG_MEAN_LOWER  = 3'd3;
   localparam logic [2:0] REG_VAR_THRESH  = 3'd4;
   localparam logic [2:0] REG_HIGH_RATIO  = 3'd5;
   localparam logic [2:0] REG_LOW_RATIO   = 3'd6;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sqsum;
      logic [CNT_W-1:0] bright;
      logic [CNT_W-1:0] dark;
      logic             ovf;
   } snap_type;

   typedef struct packed {
      logic [7:0]         over_limit;
      logic [7:0]         under_limit;
      logic [7:0]         mean_upper;
      logic [7:0]         mean_lower;
      logic [OUT_W-1:0]   var_threshold;
      logic [RATIO_W-1:0] high_ratio;
      logic [RATIO_W-1:0] low_ratio;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       mean;
      logic [OUT_W-1:0] variance;
      logic [OUT_W-1:0] bright;
      logic [OUT_W-1:0] dark;
      logic [2:0]       status;
      logic             ovf;
   } result_type;

endpackage

`default_nettype wire

### design/image_exposure_quality_check.sv
// Image exposure quality check: a pixel is accepted in every cycle while the
// snapshot queue has room (full low). Each image's last pixel moves a snapshot of
// its statistics into a two-entry queue; the back end then works through each
// image (an 8-step and a 24-step bit-serial divider plus five multiply and decide
// steps) before the result appears at the result ports. Pixel input stalls only
// when two finished images already wait for the back end.
// Depends on iexq_pkg, iexq_front, iexq_queue and iexq_back.
`default_nettype none

module image_exposure_quality_check (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [7:0]                  req_pixel,
   input  wire logic                        req_last_pixel,
   output logic                             empty,
   input  wire logic                        pop,
   output logic [7:0]                       rsp_mean_value,
   output logic [22:0]                      rsp_variance_q8,
   output logic [22:0]                      rsp_bright_count,
   output logic [22:0]                      rsp_dark_count,
   output logic [2:0]                       rsp_status,
   output logic                             rsp_overflow,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [iexq_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import iexq_pkg::*;

   localparam cfg_type CFG_RESET = '{
      over_limit:    8'd250,
      under_limit:   8'd5,
      mean_upper:    8'd200,
      mean_lower:    8'd30,
      var_threshold: 23'd25600,
      high_ratio:    17'd3277,
      low_ratio:     17'd3277
   };

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;
   logic       snap_push, q_full, q_empty, q_pop;
   snap_type   snap, q_data;
   result_type result;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_OVER_LIMIT:  cfg_in.over_limit    = pwdata[7:0];
            REG_UNDER_LIMIT: cfg_in.under_limit   = pwdata[7:0];
            REG_MEAN_UPPER:  cfg_in.mean_upper    = pwdata[7:0];
            REG_MEAN_LOWER:  cfg_in.mean_lower    = pwdata[7:0];
            REG_VAR_THRESH:  cfg_in.var_threshold = pwdata[OUT_W-1:0];
            REG_HIGH_RATIO:  cfg_in.high_ratio    = pwdata[RATIO_W-1:0];
            REG_LOW_RATIO:   cfg_in.low_ratio     = pwdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OVER_LIMIT:  prdata = 32'(cfg_ff.over_limit);
         REG_UNDER_LIMIT: prdata = 32'(cfg_ff.under_limit);
         REG_MEAN_UPPER:  prdata = 32'(cfg_ff.mean_upper);
         REG_MEAN_LOWER:  prdata = 32'(cfg_ff.mean_lower);
         REG_VAR_THRESH:  prdata = 32'(cfg_ff.var_threshold);
         REG_HIGH_RATIO:  prdata = 32'(cfg_ff.high_ratio);
         REG_LOW_RATIO:   prdata = 32'(cfg_ff.low_ratio);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iexq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pixel      (req_pixel),
      .last_pixel (req_last_pixel),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .full       (full),
      .snap_push  (snap_push),
      .snap       (snap)
   );

   iexq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (snap_push),
      .wr_data (snap),
      .pop     (q_pop),
      .full    (q_full),
      .empty   (q_empty),
      .rd_data (q_data)
   );

   iexq_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .cfg     (cfg_ff),
      .pop     (pop),
      .q_pop   (q_pop),
      .empty   (empty),
      .result  (result)
   );

   assign rsp_mean_value   = result.mean;
   assign rsp_variance_q8  = result.variance;
   assign rsp_bright_count = result.bright;
   assign rsp_dark_count   = result.dark;
   assign rsp_status       = result.status;
   assign rsp_overflow     = result.ovf;

endmodule

`default_nettype wire

### design/iexq_front.sv
// Front end: accepts pixels, accumulates per-image statistics, hands a snapshot
// to the image queue on the last pixel. Depends on iexq_pkg.
`default_nettype none

module iexq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [7:0]        pixel,
   input  wire logic              last_pixel,
   input  wire iexq_pkg::cfg_type cfg,
   input  wire logic              q_full,
   output logic                   full,
   output logic                   snap_push,
   output iexq_pkg::snap_type     snap
);
   import iexq_pkg::*;

   snap_type acc_ff, acc_in, upd;
   logic     accept;

   assign accept    = push && !q_full;
   assign full      = q_full;
   assign snap_push = accept && last_pixel;
   assign snap      = upd;

   always_comb begin
      upd = acc_ff;
      if (accept) begin
         if (acc_ff.count == MAX_CNT) begin
            upd.ovf = 1'b1;
         end else begin
            upd.count  = acc_ff.count + CNT_W'(1);
            upd.sum    = acc_ff.sum + SUM_W'(pixel);
            upd.sqsum  = acc_ff.sqsum + SQ_W'(16'(pixel * pixel));
            upd.bright = acc_ff.bright + CNT_W'(pixel > cfg.over_limit);
            upd.dark   = acc_ff.dark + CNT_W'(pixel < cfg.under_limit);
         end
      end
      acc_in = snap_push ? '0 : upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

### design/iexq_queue.sv
// Short queue of per-image snapshots between front and back end.
// Depends on iexq_pkg.
`default_nettype none

module iexq_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire iexq_pkg::snap_type wr_data,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output iexq_pkg::snap_type      rd_data
);
   import iexq_pkg::*;

   snap_type               entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]       cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full    = cnt_ff == (Q_PTR_W + 1)'(Q_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### design/iexq_back.sv
// Back end: per image, bit-serial divisions for mean and variance, ratio checks,
// status decision, result register. Depends on iexq_pkg.
`default_nettype none

module iexq_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire iexq_pkg::snap_type q_data,
   input  wire iexq_pkg::cfg_type  cfg,
   input  wire logic               pop,
   output logic                    q_pop,
   output logic                    empty,
   output iexq_pkg::result_type    result
);
   import iexq_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_MUL3 = 3'd4;
   localparam logic [2:0] S_RHI  = 3'd5;
   localparam logic [2:0] S_RLO  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              phase_ff, phase_in;
   logic              out_valid_ff, out_valid_in;
   snap_type          snap_ff, snap_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  dvd_ff, dvd_in, quo_ff, quo_in;
   logic [7:0]        mean_ff, mean_in;
   logic [OUT_W-1:0]  var_ff, var_in;
   logic [15:0]       mm_ff, mm_in;
   logic [CALC_W-1:0] dev_ff, dev_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              hi_ff, hi_in;
   result_type        out_ff, out_in;

   logic [CNT_W:0]    rem_sh;
   logic              ge;
   logic [QUO_W-1:0]  quo_fin;
   logic              n_zero;
   logic [DEV_W-1:0]  msum, nmm;
   logic [CALC_W-1:0] dev_sum;
   logic              lo_hit;
   logic [2:0]        status;
   logic              out_free;

   function automatic logic [OUT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
      logic [CNT_W:0] ve;
      ve = (CNT_W + 1)'(v);
      return (ve > (CNT_W + 1)'(SAT23)) ? SAT23 : OUT_W'(v);
   endfunction

   assign empty    = !out_valid_ff;
   assign result   = out_ff;
   assign out_free = !out_valid_ff || pop;
   assign n_zero   = snap_ff.count == '0;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[QUO_W-1]};
      ge      = rem_sh >= (CNT_W + 1)'(snap_ff.count);
      quo_fin = {quo_ff[QUO_W-2:0], ge};
      msum    = mean_ff * snap_ff.sum;
      nmm     = snap_ff.count * mm_ff;
      dev_sum = dev_ff + CALC_W'(nmm);
      lo_hit  = (PROD_W'({snap_ff.dark, 16'b0})) > prod_ff;
      priority if (mean_ff > cfg.mean_upper) begin
         status = STATUS_BRIGHT;
      end else if (mean_ff < cfg.mean_lower) begin
         status = STATUS_DARK;
      end else if (var_ff < cfg.var_threshold) begin
         status = STATUS_FLAT;
      end else if (hi_ff) begin
         status = STATUS_MANY_HIGH;
      end else if (lo_hit) begin
         status = STATUS_MANY_LOW;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !pop;
      snap_in      = snap_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      mm_in        = mm_ff;
      dev_in       = dev_ff;
      prod_in      = prod_ff;
      hi_in        = hi_ff;
      out_in       = out_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               snap_in  = q_data;
               rem_in   = q_data.sum[SUM_W-1:8];
               dvd_in   = {q_data.sum[7:0], 16'b0};
               quo_in   = '0;
               iter_in  = ITER_W'(8);
               phase_in = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = ge ? CNT_W'(rem_sh - (CNT_W + 1)'(snap_ff.count)) : CNT_W'(rem_sh);
            dvd_in  = {dvd_ff[QUO_W-2:0], 1'b0};
            quo_in  = quo_fin;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               if (!phase_ff) begin
                  mean_in  = n_zero ? 8'd0 : quo_fin[7:0];
                  state_in = S_MUL1;
               end else begin
                  if (n_zero) begin
                     var_in = '0;
                  end else if (quo_fin > QUO_W'(SAT23)) begin
                     var_in = SAT23;
                  end else begin
                     var_in = OUT_W'(quo_fin);
                  end
                  state_in = S_RHI;
               end
            end
         end
         S_MUL1: begin
            mm_in    = mean_ff * mean_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            dev_in   = CALC_W'(snap_ff.sqsum) - CALC_W'({msum, 1'b0});
            state_in = S_MUL3;
         end
         S_MUL3: begin
            rem_in   = dev_sum[DEV_W-1:16];
            dvd_in   = {dev_sum[15:0], 8'b0};
            quo_in   = '0;
            iter_in  = ITER_W'(QUO_W);
            phase_in = 1'b1;
            state_in = S_DIV;
         end
         S_RHI: begin
            prod_in  = snap_ff.count * cfg.high_ratio;
            state_in = S_RLO;
         end
         S_RLO: begin
            hi_in    = (PROD_W'({snap_ff.bright, 16'b0})) > prod_ff;
            prod_in  = snap_ff.count * cfg.low_ratio;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_in.mean     = mean_ff;
               out_in.variance = var_ff;
               out_in.bright   = sat_cnt(snap_ff.bright);
               out_in.dark     = sat_cnt(snap_ff.dark);
               out_in.status   = status;
               out_in.ovf      = snap_ff.ovf;
               out_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         iter_ff      <= '0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         iter_ff      <= iter_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      mean_ff <= mean_in;
      var_ff  <= var_in;
      mm_ff   <= mm_in;
      dev_ff  <= dev_in;
      prod_ff <= prod_in;
      hi_ff   <= hi_in;
      out_ff  <= out_in;
   end

endmodule

`default_nettype wire

### design/iexq_checker.sv
// Port-level checks for image_exposure_quality_check, attached by bind.
// Depends on iexq_pkg.
`default_nettype none

module iexq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [7:0]  rsp_mean_value,
   input wire logic [22:0] rsp_variance_q8,
   input wire logic [22:0] rsp_bright_count,
   input wire logic [22:0] rsp_dark_count,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_overflow
);
   import iexq_pkg::*;

   // after reset nothing waits and pixels are taken
   a_reset_clean: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("not idle after reset");

   // a waiting result transaction holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_status) && $stable(rsp_mean_value)
                            && $stable(rsp_variance_q8) && $stable(rsp_bright_count)
                            && $stable(rsp_dark_count) && $stable(rsp_overflow)))
      else $error("result changed while waiting");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status <= STATUS_MANY_LOW))
      else $error("undefined status code");

   // saturation counts never exceed the pixel limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_bright_count <= OUT_W'(MAX_PIXELS)
                  && rsp_dark_count <= OUT_W'(MAX_PIXELS)))
      else $error("saturation count above pixel limit");

endmodule

bind image_exposure_quality_check iexq_checker u_iexq_checker (.*);

`default_nettype wire
